FILE: design/sem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W     = 8;      // one color component
  localparam int NCH       = 3;      // red, green, blue
  localparam int IW_W      = 11;     // image_width register
  localparam int IH_W      = 13;     // image_height register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;

  localparam logic [IW_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IH_W-1:0] HEIGHT_RST = 13'd480;

  localparam int GRAD_W = 11;        // signed gradient, |g| <= 1020
  localparam int SQ_W   = 20;        // g*g
  localparam int N_W    = 21;        // gx*gx + gy*gy
  localparam int ROOT_W = 12;        // floor root bits

  localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    logic capture;     // latch pixel, start line store read
    logic advance;     // shift window, write line store, step input counters
    logic grad;        // register Gx/Gy
    logic square;      // register Gx^2+Gy^2
    logic root_start;
    logic root_step;
    logic load_out;    // load result register, step result counters
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic root_done;
  } dp_status_t;

endpackage

FILE: design/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// 3x3 Sobel gradient magnitude per color channel on a raster RGB stream.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_*     | in  | tdata {blue, green, red}, tuser drain (black/flush item)
//  m_*     | out | tdata {edge_blue, edge_green, edge_red}, tlast frame_end
//  cfg_*   | in  | index 0 image_width, index 1 image_height, write only
//
//  A pixel producing no result returns to idle after the window update; one
//  producing a result also runs the 12-step bit-serial square root.
//  Results lag one row plus one pixel; width+1 drain items flush a frame.
//  Line stores have no reset; reset clears window, counters and control state.
//  A held result does not block the next input transfer; the next result
//  waits until the held one has been transferred.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [NCH*PIX_W-1:0] s_tdata,   // red, green, blue
  input  logic                 s_tuser,   // drain
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [NCH*PIX_W-1:0] m_tdata,   // edge_red, edge_green, edge_blue
  output logic                 m_tlast,   // frame_end
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  sem_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: design/sem_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sem_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: per pixel read, window update, gradient, square, root, output.
// ----------------------------------------------------------------------------
module sem_ctrl
  import sem_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_GRAD, S_SQ, S_ROOT, S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.advance = 1'b1;
        state_next  = status.emit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.square     = 1'b1;
        cmd.root_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        if (status.root_done) begin
          state_next = S_DONE;
        end else begin
          cmd.root_step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_then_advance: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> cmd.advance)
    else $error("transfer not followed by window update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_tready))
    else $error("result register overwritten while held");

  a_step_until_done: assert property (@(posedge clk) disable iff (rst)
    cmd.root_step |-> !status.root_done)
    else $error("root step after completion");

  a_busy_while_computing: assert property (@(posedge clk) disable iff (rst)
    (cmd.grad || cmd.square || cmd.root_step) |-> !s_tready)
    else $error("input ready while computing");
`endif

endmodule

FILE: design/sem_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_dp
// Datapath: line stores, 3x3 window, counters, Sobel gradients, rounded root.
// ----------------------------------------------------------------------------
module sem_dp
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [NCH*PIX_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic [NCH*PIX_W-1:0] m_tdata,
  output logic                 m_tlast,
  input  dp_cmd_t              cmd,
  output dp_status_t           status
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > IW_W) ? WW : IW_W;

  logic [IW_W-1:0] image_width;
  logic [IH_W-1:0] image_height;
  logic [WW-1:0]   weff;
  logic [IH_W-1:0] heff;

  logic [CW-1:0]   col;
  logic [WW:0]     prime;
  logic [CW-1:0]   rcol;
  logic [IH_W-1:0] rrow;
  logic            restart;

  pix_t            pixel;
  pix_t            win [3][3];
  logic [2*NCH*PIX_W-1:0] rd_data;
  pix_t            upper_rd, middle_rd;

  logic            top_ok, bot_ok, left_ok, right_ok, last;
  logic signed [GRAD_W-1:0] a [NCH][3][3];
  logic signed [GRAD_W-1:0] gx_c [NCH], gy_c [NCH];
  logic signed [GRAD_W-1:0] gx [NCH], gy [NCH];
  logic signed [2*GRAD_W-1:0] sqx [NCH], sqy [NCH];
  logic [N_W-1:0]    n [NCH];
  logic [ROOT_W-1:0] s [NCH];
  logic [ROOT_W-1:0] bitm;
  logic [ROOT_W-1:0] trial [NCH];
  logic [2*ROOT_W-1:0] trial_sq [NCH];
  logic [2*ROOT_W:0]   fin [NCH];
  logic [ROOT_W:0]     rnd [NCH];
  logic [PIX_W-1:0]    edge_px [NCH];

  // effective frame size
  always_comb begin
    if (image_width == '0) begin
      weff = WW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(image_width);
    end
    heff = (image_height == '0) ? IH_W'(1) : image_height;
  end

  assign status.emit      = (prime >= (WW + 1)'(weff) + (WW + 1)'(1));
  assign status.root_done = (bitm == '0);

  assign top_ok   = (rrow != '0);
  assign bot_ok   = ((IH_W + 1)'(rrow) + (IH_W + 1)'(1)) < (IH_W + 1)'(heff);
  assign left_ok  = (rcol != '0);
  assign right_ok = (WW'(rcol) + WW'(1)) < weff;
  assign last     = !right_ok && !bot_ok;
  assign restart  = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  assign upper_rd  = rd_data[2*NCH*PIX_W-1:NCH*PIX_W];
  assign middle_rd = rd_data[NCH*PIX_W-1:0];

  sem_ram #(
    .WIDTH (2 * NCH * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (cmd.advance),
    .waddr (col),
    .wdata ({middle_rd, pixel}),
    .raddr (col),
    .rdata (rd_data)
  );

  // config and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      col          <= '0;
      prime        <= '0;
      rcol         <= '0;
      rrow         <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_WIDTH) begin
        image_width <= cfg_data[IW_W-1:0];
      end
      if (cfg_we && cfg_index == REG_HEIGHT) begin
        image_height <= cfg_data[IH_W-1:0];
      end
      if (restart || (cmd.load_out && last)) begin
        col   <= '0;
        prime <= '0;
        rcol  <= '0;
        rrow  <= '0;
      end else begin
        if (cmd.advance) begin
          if (WW'(col) + WW'(1) >= weff) begin
            col <= '0;
          end else begin
            col <= col + CW'(1);
          end
          if (!status.emit) begin
            prime <= prime + (WW + 1)'(1);
          end
        end
        if (cmd.load_out) begin
          if (right_ok) begin
            rcol <= rcol + CW'(1);
          end else begin
            rcol <= '0;
            rrow <= rrow + IH_W'(1);
          end
        end
      end
    end
  end

  // window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cmd.advance) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= upper_rd;
      win[1][2] <= middle_rd;
      win[2][2] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pixel <= s_tuser ? '0 : pix_t'(s_tdata);
    end
  end

  // masked Sobel taps
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r == 0 && !top_ok) || (r == 2 && !bot_ok) ||
              (c == 0 && !left_ok) || (c == 2 && !right_ok)) begin
            a[ch][r][c] = '0;
          end else begin
            a[ch][r][c] = $signed(GRAD_W'(win[r][c][ch]));
          end
        end
      end
      gx_c[ch] = a[ch][0][2] + (a[ch][1][2] <<< 1) + a[ch][2][2]
               - a[ch][0][0] - (a[ch][1][0] <<< 1) - a[ch][2][0];
      gy_c[ch] = a[ch][2][0] + (a[ch][2][1] <<< 1) + a[ch][2][2]
               - a[ch][0][0] - (a[ch][0][1] <<< 1) - a[ch][0][2];
      sqx[ch]  = gx[ch] * gx[ch];
      sqy[ch]  = gy[ch] * gy[ch];
      trial[ch]    = s[ch] | bitm;
      trial_sq[ch] = trial[ch] * trial[ch];
      fin[ch]  = (2 * ROOT_W + 1)'(s[ch]) * (2 * ROOT_W + 1)'(s[ch])
               + (2 * ROOT_W + 1)'(s[ch]);
      rnd[ch]  = ((2 * ROOT_W + 1)'(n[ch]) > fin[ch]) ?
                 (ROOT_W + 1)'(s[ch]) + (ROOT_W + 1)'(1) : (ROOT_W + 1)'(s[ch]);
      edge_px[ch] = (rnd[ch] > (ROOT_W + 1)'(SAT_MAX)) ? SAT_MAX : rnd[ch][PIX_W-1:0];
    end
  end

  // gradient, square, root
  always_ff @(posedge clk) begin
    if (rst) begin
      bitm <= '0;
    end else if (cmd.root_start) begin
      bitm <= ROOT_W'(1) << (ROOT_W - 1);
    end else if (cmd.root_step) begin
      bitm <= bitm >> 1;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NCH; ch++) begin
      if (cmd.grad) begin
        gx[ch] <= gx_c[ch];
        gy[ch] <= gy_c[ch];
      end
      if (cmd.square) begin
        n[ch] <= N_W'(sqx[ch][SQ_W-1:0]) + N_W'(sqy[ch][SQ_W-1:0]);
      end
      if (cmd.root_start) begin
        s[ch] <= '0;
      end else if (cmd.root_step) begin
        if (trial_sq[ch] <= (2 * ROOT_W)'(n[ch])) begin
          s[ch] <= trial[ch];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {edge_px[2], edge_px[1], edge_px[0]};
      m_tlast <= last;
    end
  end

endmodule
